// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the UTF-8 decoder RTL.
// Expects aclk and aresetn to be visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define UD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("utf8 decoder assertion failed");

// When cond holds, cons holds in the next cycle
`define UD_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error("utf8 decoder assertion failed");

`endif

// File: hw/rtl/utf8d_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies; imported by the decode and expand stages.
package utf8d_pkg;

    localparam int CpW   = 21;
    localparam int UsedW = 3;
    localparam int CntW  = 3;

    localparam logic [CpW-1:0] REPL_CP   = 21'h00FFFD;
    localparam logic [CpW-1:0] MAX_CP    = 21'h10FFFF;
    localparam logic [CpW-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CpW-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CpW-1:0] MIN_CP_2  = 21'h000080;
    localparam logic [CpW-1:0] MIN_CP_3  = 21'h000800;
    localparam logic [CpW-1:0] MIN_CP_4  = 21'h010000;

    // Results caused by one byte: repl_cnt replacements, then an optional tail
    typedef struct packed {
        logic [CntW-1:0]  repl_cnt;
        logic             tail_valid;
        logic [CpW-1:0]   tail_cp;
        logic             tail_good;
        logic [UsedW-1:0] tail_used;
        logic             fin;
    } grp_t;

endpackage

// File: hw/rtl/utf8d_decode.sv
// Decode stage: sequence state and per-byte result group.
// Depends on utf8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8d_decode (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_accept,
    input  logic [7:0]        byte_value,
    input  logic              final_byte,
    output utf8d_pkg::grp_t   grp
);
    import utf8d_pkg::*;

    logic [1:0]     exp_reg, exp_next;
    logic [1:0]     seen_reg, seen_next;
    logic [CpW-1:0] acc_reg, acc_next;

    // start-of-sequence decode of the incoming byte
    logic           st_ascii, st_lead;
    logic [1:0]     st_exp;
    logic [CpW-1:0] st_acc;
    logic           is_cont;
    logic [CpW-1:0] acc_cat;
    logic [1:0]     seen_inc;
    logic [CpW-1:0] min_cp;
    logic           cp_ok;

    always_comb begin
        st_ascii = !byte_value[7];
        st_lead  = 1'b1;
        st_exp   = 2'd0;
        st_acc   = '0;
        priority if (byte_value[7:5] == 3'b110) begin
            st_exp = 2'd1;
            st_acc = {16'd0, byte_value[4:0]};
        end else if (byte_value[7:4] == 4'b1110) begin
            st_exp = 2'd2;
            st_acc = {17'd0, byte_value[3:0]};
        end else if (byte_value[7:3] == 5'b11110) begin
            st_exp = 2'd3;
            st_acc = {18'd0, byte_value[2:0]};
        end else begin
            st_lead = 1'b0;
        end
    end

    // continuation accumulate and scalar range check
    always_comb begin
        is_cont  = (byte_value[7:6] == 2'b10);
        acc_cat  = {acc_reg[CpW-7:0], byte_value[5:0]};
        seen_inc = seen_reg + 2'd1;
        unique case (exp_reg)
            2'd1:    min_cp = MIN_CP_2;
            2'd2:    min_cp = MIN_CP_3;
            default: min_cp = MIN_CP_4;
        endcase
        cp_ok = (acc_cat >= min_cp) && (acc_cat <= MAX_CP)
                && !((acc_cat >= SURR_LO) && (acc_cat <= SURR_HI));
    end

    // next state and result group
    always_comb begin
        exp_next  = exp_reg;
        seen_next = seen_reg;
        acc_next  = acc_reg;
        grp       = '0;
        grp.fin   = final_byte;
        if ((exp_reg != 2'd0) && is_cont) begin
            if (seen_inc >= exp_reg) begin
                if (cp_ok) begin
                    grp.tail_valid = 1'b1;
                    grp.tail_cp    = acc_cat;
                    grp.tail_good  = 1'b1;
                    grp.tail_used  = {1'b0, exp_reg} + 3'd1;
                end else begin
                    grp.repl_cnt = {1'b0, exp_reg} + 3'd1;
                end
                exp_next  = 2'd0;
                seen_next = 2'd0;
                acc_next  = '0;
            end else if (final_byte) begin
                grp.repl_cnt = {1'b0, seen_inc} + 3'd1;
                exp_next  = 2'd0;
                seen_next = 2'd0;
                acc_next  = '0;
            end else begin
                seen_next = seen_inc;
                acc_next  = acc_cat;
            end
        end else begin
            // broken sequence first flushes lead and continuations seen
            if (exp_reg != 2'd0) begin
                grp.repl_cnt = {1'b0, seen_reg} + 3'd1;
            end
            exp_next  = 2'd0;
            seen_next = 2'd0;
            acc_next  = '0;
            priority if (st_ascii) begin
                grp.tail_valid = 1'b1;
                grp.tail_cp    = {13'd0, byte_value};
                grp.tail_good  = 1'b1;
                grp.tail_used  = 3'd1;
            end else if (st_lead && !final_byte) begin
                exp_next = st_exp;
                acc_next = st_acc;
            end else begin
                grp.tail_valid = 1'b1;
                grp.tail_cp    = REPL_CP;
                grp.tail_good  = 1'b0;
                grp.tail_used  = 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_reg  <= 2'd0;
            seen_reg <= 2'd0;
            acc_reg  <= '0;
        end else if (in_accept) begin
            exp_reg  <= exp_next;
            seen_reg <= seen_next;
            acc_reg  <= acc_next;
        end
    end

    `UD_ASSERT(a_idle_no_seen, (exp_reg == 2'd0) |-> (seen_reg == 2'd0))
    `UD_ASSERT(a_seen_below_exp, (exp_reg != 2'd0) |-> (seen_reg < exp_reg))
    `UD_ASSERT_NEXT(a_fin_goes_idle, in_accept && final_byte, exp_reg == 2'd0)

endmodule

// File: hw/rtl/utf8d_expand.sv
// Expand stage: holds one result group and delivers its words in order.
// Depends on utf8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8d_expand (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        grp_load,
    input  utf8d_pkg::grp_t             grp_in,
    output logic                        space,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [utf8d_pkg::CpW-1:0]   code_point,
    output logic                        is_good,
    output logic [utf8d_pkg::UsedW-1:0] bytes_used,
    output logic                        run_last,
    output logic                        text_end
);
    import utf8d_pkg::*;

    logic            grp_valid_reg;
    grp_t            grp_reg;
    logic            cur_last;
    logic            out_take;
    logic            in_nonempty;

    // current word from the held group
    always_comb begin
        cur_last = grp_reg.tail_valid ? (grp_reg.repl_cnt == 3'd0)
                                      : (grp_reg.repl_cnt == 3'd1);
        if (grp_reg.repl_cnt != 3'd0) begin
            code_point = REPL_CP;
            is_good    = 1'b0;
            bytes_used = 3'd1;
        end else begin
            code_point = grp_reg.tail_cp;
            is_good    = grp_reg.tail_good;
            bytes_used = grp_reg.tail_used;
        end
        out_valid   = grp_valid_reg;
        run_last    = cur_last;
        text_end    = cur_last && grp_reg.fin;
        out_take    = grp_valid_reg && out_ready;
        space       = !grp_valid_reg || (out_take && cur_last);
        in_nonempty = (grp_in.repl_cnt != 3'd0) || grp_in.tail_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_valid_reg <= 1'b0;
        end else if (space) begin
            grp_valid_reg <= grp_load && in_nonempty;
        end
    end

    always_ff @(posedge aclk) begin
        if (space) begin
            if (grp_load) begin
                grp_reg <= grp_in;
            end
        end else if (out_take && (grp_reg.repl_cnt != 3'd0)) begin
            grp_reg.repl_cnt <= grp_reg.repl_cnt - 3'd1;
        end
    end

    `UD_ASSERT(a_held_nonempty,
        grp_valid_reg |-> ((grp_reg.repl_cnt != 3'd0) || grp_reg.tail_valid))
    `UD_ASSERT(a_repl_max, grp_valid_reg |-> (grp_reg.repl_cnt <= 3'd4))
    `UD_ASSERT_NEXT(a_more_pending, out_take && !cur_last, grp_valid_reg)

endmodule

// File: hw/rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder. Takes one byte per input word and returns decoded
// scalar values, one per output word. A valid sequence gives one word with
// its length in bytes_used; a malformed sequence (bad lead, missing
// continuation, overlong form, surrogate, value above 0x10FFFF, or a cut-off
// sequence at the end of text) gives one U+FFFD word per byte involved, and
// a byte that broke a sequence is decoded afresh. One byte causes zero to
// four words; tlast marks the last word caused by a byte and tuser marks the
// last word of the text. A byte is accepted when no group is held or in the
// cycle the previous byte's last word is taken, so single-result bytes run
// at one byte per clock while m_tready is high; a byte giving more words holds
// the input until its last word is taken (a single group register). Bytes that
// only extend an open sequence give no word, but like any other byte they
// wait while an earlier byte's words are still held in the group register.
// Depends on utf8d_pkg, utf8d_decode and utf8d_expand.
module utf8_stream_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [20:0] code_point, [21] is_good, [24:22] bytes_used
    output logic        m_tlast,   // run_last
    output logic        m_tuser    // text_end
);
    import utf8d_pkg::*;

    grp_t             grp;
    logic             in_accept;
    logic             space;
    logic [CpW-1:0]   code_point;
    logic             is_good;
    logic [UsedW-1:0] bytes_used;

    assign s_tready  = space;
    assign in_accept = s_tvalid && s_tready;
    assign m_tdata   = {7'd0, bytes_used, is_good, code_point};

    utf8d_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .byte_value (s_tdata),
        .final_byte (s_tlast),
        .grp        (grp)
    );

    utf8d_expand u_expand (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .grp_load   (in_accept),
        .grp_in     (grp),
        .space      (space),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .code_point (code_point),
        .is_good    (is_good),
        .bytes_used (bytes_used),
        .run_last   (m_tlast),
        .text_end   (m_tuser)
    );

endmodule
